FILE: rtl/sbc_pkg.sv
// shared types and field widths for the systematic block code codec
package sbc_pkg;

   localparam int WORD_W   = 15;
   localparam int SYN_W    = 4;
   localparam int POS_W    = 4;
   localparam int MATRIX_W = 44;

   typedef enum logic {
      KIND_ENCODE = 1'b0,
      KIND_DECODE = 1'b1
   } kind_type;

   typedef logic [WORD_W-1:0]   word_type;
   typedef logic [SYN_W-1:0]    syn_type;
   typedef logic [POS_W-1:0]    pos_type;
   typedef logic [MATRIX_W-1:0] matrix_type;

   typedef struct packed {
      word_type result_word;
      syn_type  syndrome;
      logic     error_found;
      pos_type  error_position;
      logic     uncorrectable;
   } rsp_type;

endpackage

FILE: rtl/sbc_req_if.sv
// request channel: operation kind and word
interface sbc_req_if;
   import sbc_pkg::*;

   logic     valid;
   logic     ready;
   kind_type kind;
   word_type word;

   modport source (output valid, output kind, output word, input ready);
   modport sink   (input valid, input kind, input word, output ready);
endinterface

FILE: rtl/sbc_rsp_if.sv
// response channel: coded or corrected word with decode status
interface sbc_rsp_if;
   import sbc_pkg::*;

   logic     valid;
   logic     ready;
   word_type result_word;
   syn_type  syndrome;
   logic     error_found;
   pos_type  error_position;
   logic     uncorrectable;

   modport source (output valid, output result_word, output syndrome, output error_found,
                   output error_position, output uncorrectable, input ready);
   modport sink   (input valid, input result_word, input syndrome, input error_found,
                   input error_position, input uncorrectable, output ready);
endinterface

FILE: rtl/sbc_core.sv
// combinational encode and single-error syndrome decode for one word
module sbc_core #(
   parameter int CODE_LEN = 15,
   parameter int DATA_LEN = 11
) (
   input  sbc_pkg::matrix_type matrix,
   input  sbc_pkg::kind_type   kind,
   input  sbc_pkg::word_type   word,
   output sbc_pkg::rsp_type    rsp
);
   import sbc_pkg::*;

   localparam int PAR_LEN = CODE_LEN - DATA_LEN;
   localparam int POS_IW  = $clog2(CODE_LEN);

   logic [PAR_LEN-1:0]  ht_row [CODE_LEN];
   logic [CODE_LEN-1:0] rx_word;
   logic [CODE_LEN-1:0] cw;
   logic [PAR_LEN-1:0]  syn;
   logic [CODE_LEN-1:0] hit;
   logic [CODE_LEN-1:0] first_hit;
   logic [POS_IW-1:0]   pos;
   logic                any_hit;
   logic                syn_nz;
   logic                is_dec;
   logic [CODE_LEN-1:0] full;
   logic                seen;

   // rows of the transposed parity check matrix
   for (genvar j = 0; j < CODE_LEN; j++) begin : g_row
      if (j < DATA_LEN) begin : g_data
         for (genvar c = 0; c < PAR_LEN; c++) begin : g_bit
            if (j * PAR_LEN + c < MATRIX_W) begin : g_in
               assign ht_row[j][c] = matrix[j*PAR_LEN+c];
            end else begin : g_out
               assign ht_row[j][c] = 1'b0;
            end
         end
      end else begin : g_unit
         for (genvar c = 0; c < PAR_LEN; c++) begin : g_bit
            assign ht_row[j][c] = (c == j - DATA_LEN);
         end
      end
   end

   // input bits beyond the port width read as zero
   for (genvar i = 0; i < CODE_LEN; i++) begin : g_rx
      if (i < WORD_W) begin : g_in
         assign rx_word[i] = word[i];
      end else begin : g_out
         assign rx_word[i] = 1'b0;
      end
   end

   assign is_dec = (kind == KIND_DECODE);

   // encode keeps only the data bits, so the same xor tree yields the parity
   always_comb begin
      cw = rx_word;
      if (!is_dec) begin
         cw = rx_word & {{PAR_LEN{1'b0}}, {DATA_LEN{1'b1}}};
      end
   end

   always_comb begin
      syn = '0;
      for (int i = 0; i < CODE_LEN; i++) begin
         syn = syn ^ (ht_row[i] & {PAR_LEN{cw[i]}});
      end
   end

   assign syn_nz = (syn != '0);

   always_comb begin
      for (int i = 0; i < CODE_LEN; i++) begin
         hit[i] = (ht_row[i] == syn);
      end
   end

   // lowest matching position wins
   always_comb begin
      seen      = 1'b0;
      first_hit = '0;
      pos       = '0;
      for (int i = 0; i < CODE_LEN; i++) begin
         if (hit[i] && !seen) begin
            first_hit[i] = 1'b1;
            pos          = POS_IW'(i);
            seen         = 1'b1;
         end
      end
   end

   assign any_hit = |hit;

   always_comb begin
      if (is_dec) begin
         full = cw;
         if (syn_nz && any_hit) begin
            full = cw ^ first_hit;
         end
      end else begin
         full = {syn, cw[DATA_LEN-1:0]};
      end
   end

   for (genvar b = 0; b < WORD_W; b++) begin : g_res
      if (b < CODE_LEN) begin : g_in
         assign rsp.result_word[b] = full[b];
      end else begin : g_out
         assign rsp.result_word[b] = 1'b0;
      end
   end

   for (genvar b = 0; b < SYN_W; b++) begin : g_syn
      if (b < PAR_LEN) begin : g_in
         assign rsp.syndrome[b] = is_dec & syn[b];
      end else begin : g_out
         assign rsp.syndrome[b] = 1'b0;
      end
   end

   for (genvar b = 0; b < POS_W; b++) begin : g_pos
      if (b < POS_IW) begin : g_in
         assign rsp.error_position[b] = is_dec & syn_nz & any_hit & pos[b];
      end else begin : g_out
         assign rsp.error_position[b] = 1'b0;
      end
   end

   assign rsp.error_found   = is_dec & syn_nz & any_hit;
   assign rsp.uncorrectable = is_dec & syn_nz & ~any_hit;

endmodule

FILE: rtl/systematic_block_code_codec_top.sv
// top level of the systematic block code codec
// a request beat passes the input register and then the result register before its response beat
// throughput: one beat per cycle; the encode/decode logic between the two registers
// holds no state, so back-to-back beats stream while the response side keeps up
// synchronous active-high reset clears the valid flags and the parity matrix to zero
module systematic_block_code_codec_top #(
   parameter int CODE_LEN = 15,
   parameter int DATA_LEN = 11
) (
   input  logic                clock,
   input  logic                reset,
   sbc_req_if.sink             req_if,
   sbc_rsp_if.source           rsp_if,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  sbc_pkg::matrix_type csr_data
);
   import sbc_pkg::*;

   matrix_type matrix_ff;
   matrix_type matrix_in;
   logic       s1_valid_ff;
   logic       s1_valid_in;
   kind_type   s1_kind_ff;
   kind_type   s1_kind_in;
   word_type   s1_word_ff;
   word_type   s1_word_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   rsp_type    rsp_data_ff;
   rsp_type    rsp_data_in;
   rsp_type    core_rsp;
   logic       advance;
   logic       req_take;

   assign csr_ready = 1'b1;

   // result register moves when empty or being drained
   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = !s1_valid_ff || advance;
   assign req_take     = req_if.valid && req_if.ready;

   sbc_core #(
      .CODE_LEN (CODE_LEN),
      .DATA_LEN (DATA_LEN)
   ) u_core (
      .matrix (matrix_ff),
      .kind   (s1_kind_ff),
      .word   (s1_word_ff),
      .rsp    (core_rsp)
   );

   always_comb begin
      matrix_in    = matrix_ff;
      s1_valid_in  = s1_valid_ff;
      s1_kind_in   = s1_kind_ff;
      s1_word_in   = s1_word_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (csr_valid && csr_ready) begin
         matrix_in = csr_data;
      end
      if (advance) begin
         rsp_valid_in = s1_valid_ff;
         rsp_data_in  = core_rsp;
      end
      if (req_if.ready) begin
         s1_valid_in = req_if.valid;
         s1_kind_in  = req_if.kind;
         s1_word_in  = req_if.word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         matrix_ff    <= matrix_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_kind_ff  <= s1_kind_in;
      s1_word_ff  <= s1_word_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.result_word    = rsp_data_ff.result_word;
   assign rsp_if.syndrome       = rsp_data_ff.syndrome;
   assign rsp_if.error_found    = rsp_data_ff.error_found;
   assign rsp_if.error_position = rsp_data_ff.error_position;
   assign rsp_if.uncorrectable  = rsp_data_ff.uncorrectable;

   // a beat held in the input register reaches the result register once it advances
   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && advance |=> rsp_valid_ff)
      else $error("input register beat lost on its way to the result register");

   // a beat accepted into an occupied input register must find it draining
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      req_take && s1_valid_ff |-> advance)
      else $error("input register overwritten before it moved on");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.error_found && rsp_data_ff.uncorrectable))
      else $error("corrected and uncorrectable both flagged");

   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.error_found |-> rsp_data_ff.error_position == '0)
      else $error("error position set without a corrected bit");

endmodule

FILE: verif/sbc_codec_checker.sv
// response checker for the block code codec: predicts every response and compares field by field
`timescale 1ns / 1ps
module sbc_codec_checker #(
   parameter int CODE_LEN = 15,
   parameter int DATA_LEN = 11
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  sbc_pkg::kind_type   req_kind,
   input  sbc_pkg::word_type   req_word,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  sbc_pkg::rsp_type    rsp_beat,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  sbc_pkg::matrix_type csr_data,
   output int                  mismatch_count,
   output int                  outstanding
);
   import sbc_pkg::*;

   localparam int PAR_LEN = CODE_LEN - DATA_LEN;

   matrix_type parity_bits;
   rsp_type    expected_q[$];

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
      parity_bits    = '0;
   end

   // row of the transposed parity check matrix for one code position
   function automatic syn_type check_row(int pos, matrix_type m);
      if (pos < DATA_LEN) begin
         return syn_type'(m[pos*PAR_LEN +: PAR_LEN]);
      end
      return syn_type'(1 << (pos - DATA_LEN));
   endfunction

   function automatic rsp_type predict_response(kind_type kind, word_type word, matrix_type m);
      rsp_type r;
      syn_type s;
      logic    hit;
      r   = '0;
      s   = '0;
      hit = 1'b0;
      if (kind == KIND_ENCODE) begin
         for (int i = 0; i < DATA_LEN; i++) begin
            if (word[i]) begin
               r.result_word[i] = 1'b1;
               s ^= check_row(i, m);
            end
         end
         // parity goes above the data, syndrome field stays clear
         r.result_word[DATA_LEN +: PAR_LEN] = s;
      end else begin
         for (int i = 0; i < CODE_LEN; i++) begin
            if (word[i]) begin
               s ^= check_row(i, m);
            end
         end
         r.result_word = word;
         r.syndrome    = s;
         if (s != '0) begin
            // first matching row wins
            for (int i = 0; i < CODE_LEN; i++) begin
               if (!hit && check_row(i, m) == s) begin
                  hit              = 1'b1;
                  r.error_position = pos_type'(i);
               end
            end
            if (hit) begin
               r.error_found = 1'b1;
               r.result_word[r.error_position] = ~r.result_word[r.error_position];
            end else begin
               r.uncorrectable = 1'b1;
            end
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t ns: response mismatch on %s, got %0h expected %0h", $realtime, what, got,
               want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         expected_q.delete();
         parity_bits = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected beat", longint'(rsp_beat.result_word), longint'(0));
            end else begin
               want = expected_q.pop_front();
               if (rsp_beat.result_word !== want.result_word) begin
                  report_mismatch("result_word", longint'(rsp_beat.result_word),
                                  longint'(want.result_word));
               end
               if (rsp_beat.syndrome !== want.syndrome) begin
                  report_mismatch("syndrome", longint'(rsp_beat.syndrome),
                                  longint'(want.syndrome));
               end
               if (rsp_beat.error_found !== want.error_found) begin
                  report_mismatch("error_found", longint'(rsp_beat.error_found),
                                  longint'(want.error_found));
               end
               if (rsp_beat.error_position !== want.error_position) begin
                  report_mismatch("error_position", longint'(rsp_beat.error_position),
                                  longint'(want.error_position));
               end
               if (rsp_beat.uncorrectable !== want.uncorrectable) begin
                  report_mismatch("uncorrectable", longint'(rsp_beat.uncorrectable),
                                  longint'(want.uncorrectable));
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_q.push_back(predict_response(req_kind, req_word, parity_bits));
         end
         if (csr_valid && csr_ready) begin
            parity_bits = csr_data;
         end
      end
      outstanding <= expected_q.size();
   end

endmodule

FILE: verif/tb_top.sv
// testbench top for the block code codec: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_top;
   import sbc_pkg::*;

   localparam int CODE_LEN    = 15;
   localparam int DATA_LEN    = 11;
   localparam int PAR_LEN     = CODE_LEN - DATA_LEN;
   localparam int CYCLE_LIMIT = 200000;
   localparam int NUM_PHASES  = 6;
   localparam int PHASE_ITEMS = 75;

   // every row distinct with two or more bits set: a proper single-error code
   localparam matrix_type HAMMING_MATRIX    = 44'hFEDCBA97653;
   localparam matrix_type ALL_ONES_MATRIX   = 44'hFFFFFFFFFFF;
   // repeated rows, a zero row and unit rows that shadow the parity positions
   localparam matrix_type SHARED_ROW_MATRIX = 44'h1F33A558012;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_valid;
   logic       csr_ready;
   matrix_type csr_data;
   int         mismatch_count;
   int         outstanding;
   int         cycle_count = 0;
   int         idle_pct = 0;
   matrix_type active_matrix = '0;

   sbc_req_if req_bus ();
   sbc_rsp_if rsp_bus ();

   systematic_block_code_codec_top #(
      .CODE_LEN (CODE_LEN),
      .DATA_LEN (DATA_LEN)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   sbc_codec_checker #(
      .CODE_LEN (CODE_LEN),
      .DATA_LEN (DATA_LEN)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .req_kind       (req_bus.kind),
      .req_word       (req_bus.word),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_beat       ({rsp_bus.result_word, rsp_bus.syndrome, rsp_bus.error_found,
                        rsp_bus.error_position, rsp_bus.uncorrectable}),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // response side back-pressure in bursts
   initial begin
      forever begin
         if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   function automatic word_type make_codeword(word_type data, matrix_type m);
      word_type cw;
      cw = '0;
      for (int j = 0; j < DATA_LEN; j++) begin
         if (data[j]) begin
            cw[j] = 1'b1;
            cw[DATA_LEN +: PAR_LEN] ^= m[j*PAR_LEN +: PAR_LEN];
         end
      end
      return cw;
   endfunction

   task automatic send_beat(kind_type kind, word_type word);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind  <= kind;
      req_bus.word  <= word;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_matrix(matrix_type m);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid     <= 1'b0;
      active_matrix  = m;
   endtask

   task automatic send_random_beat();
      int       pick;
      word_type cw;
      pick = $urandom_range(99);
      cw   = make_codeword(word_type'($urandom), active_matrix);
      if (pick < 35) begin
         send_beat(KIND_ENCODE, word_type'($urandom));
      end else if (pick < 55) begin
         send_beat(KIND_DECODE, cw);
      end else if (pick < 85) begin
         send_beat(KIND_DECODE, cw ^ (word_type'(1) << $urandom_range(CODE_LEN - 1)));
      end else if (pick < 93) begin
         cw ^= word_type'(1) << $urandom_range(CODE_LEN - 1);
         send_beat(KIND_DECODE, cw ^ (word_type'(1) << $urandom_range(CODE_LEN - 1)));
      end else begin
         send_beat(KIND_DECODE, word_type'($urandom));
      end
   endtask

   initial begin
      matrix_type phase_matrix[NUM_PHASES];
      int         phase_idle[NUM_PHASES];
      word_type   clean;
      reset         <= 1'b1;
      csr_valid     <= 1'b0;
      csr_data      <= '0;
      req_bus.valid <= 1'b0;
      req_bus.kind  <= KIND_ENCODE;
      req_bus.word  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // matrix still at reset: only parity positions feed the syndrome
      send_beat(KIND_ENCODE, 15'h7FFF);
      send_beat(KIND_DECODE, 15'h7FFF);
      send_beat(KIND_DECODE, 15'h0800);
      send_beat(KIND_DECODE, 15'h07FF);

      write_matrix(HAMMING_MATRIX);
      send_beat(KIND_ENCODE, 15'h0000);
      send_beat(KIND_ENCODE, 15'h07FF);
      send_beat(KIND_ENCODE, 15'h7800);
      send_beat(KIND_ENCODE, 15'h0001);
      send_beat(KIND_ENCODE, 15'h0400);
      send_beat(KIND_DECODE, 15'h0000);
      send_beat(KIND_DECODE, 15'h7FFF);
      clean = make_codeword(15'h05A5, HAMMING_MATRIX);
      send_beat(KIND_DECODE, clean);
      send_beat(KIND_DECODE, clean ^ 15'h0001);
      send_beat(KIND_DECODE, clean ^ 15'h0400);
      send_beat(KIND_DECODE, clean ^ 15'h0800);
      send_beat(KIND_DECODE, clean ^ 15'h4000);
      send_beat(KIND_DECODE, make_codeword(15'h07FF, HAMMING_MATRIX) ^ 15'h0080);
      // double error lands on a wrong position
      send_beat(KIND_DECODE, make_codeword(15'h0123, HAMMING_MATRIX) ^ 15'h0003);

      // every data row equals the all-ones syndrome: position 0 shadows the rest
      write_matrix(ALL_ONES_MATRIX);
      send_beat(KIND_DECODE, 15'h0001);
      send_beat(KIND_DECODE, 15'h7800);
      send_beat(KIND_ENCODE, 15'h07FF);

      phase_matrix[0][31:0]  = $urandom;
      phase_matrix[0][43:32] = 12'($urandom_range(4095));
      phase_matrix[1]        = HAMMING_MATRIX;
      phase_matrix[2]        = SHARED_ROW_MATRIX;
      phase_matrix[3]        = '0;
      phase_matrix[4]        = ALL_ONES_MATRIX;
      phase_matrix[5][31:0]  = $urandom;
      phase_matrix[5][43:32] = 12'($urandom_range(4095));
      phase_idle             = '{30, 50, 0, 25, 40, 0};

      for (int p = 0; p < NUM_PHASES; p++) begin
         idle_pct = phase_idle[p];
         write_matrix(phase_matrix[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // hold off mid-stream until the pipe is empty
            if (p == 1 && n == PHASE_ITEMS / 2) begin
               wait_drained();
            end
            send_random_beat();
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
